// ===== rtl/core/pgt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

	// Sample format
	localparam int FRAC_BITS   = 16;
	localparam int UW          = FRAC_BITS + 1;     // uniform sample, closed [0,1]
	localparam int XW          = FRAC_BITS + 1;     // |2u - 1|
	localparam int XSQW        = 2 * FRAC_BITS + 1; // x squared
	localparam int WW          = 2 * FRAC_BITS;     // accepted radius squared

	// Log / divide pipeline
	localparam int KW          = 5;                 // MSB index of w
	localparam int MW          = 32;                // Q1.31 mantissa
	localparam int YW          = 32;                // log2 fraction bits
	localparam int LOG_STEPS   = 32;
	localparam int QW          = 33;                // x^2/w quotient, Q1.32
	localparam int ITER_STAGES = 33;

	// Scaling and square root
	localparam int NLW         = 38;
	localparam int R8W         = QW - 8;
	localparam int PW          = NLW + R8W;
	localparam int TW          = 40;
	localparam int SW          = 20;
	localparam int SQRT_STAGES = 20;
	localparam int SCW         = 16;
	localparam int OW          = 24;

	localparam logic [YW-1:0] LN2_Q32 = 32'd2977044472;
	localparam logic [OW-1:0] OUT_MAX = 24'h7FFFFF;
	localparam logic [OW-1:0] OUT_MIN = 24'h800000;
	localparam logic [SCW-1:0] SCALE_RESET = 16'd4096;

	typedef enum logic [0:0] {
		REG_SCALE  = 1'b0,
		REG_SERIAL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic            vld;
		logic            neg1;
		logic            neg2;
		logic [KW-1:0]   k;
		logic [MW-1:0]   m;
		logic [YW-1:0]   y;
		logic [WW-1:0]   d;
		logic [QW-1:0]   rem1;
		logic [QW-1:0]   rem2;
		logic [QW-1:0]   q1;
		logic [QW-1:0]   q2;
	} iter_t;

	typedef struct packed {
		logic            vld;
		logic            neg1;
		logic            neg2;
		logic [TW-1:0]   v1;
		logic [TW-1:0]   v2;
		logic [TW-1:0]   res1;
		logic [TW-1:0]   res2;
	} sqrt_t;

endpackage

`default_nettype wire

// ===== rtl/core/pgt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pgt_in_if
	import pgt_pkg::*;
();
	logic          valid;
	logic          ready;
	logic [UW-1:0] uniform_a;
	logic [UW-1:0] uniform_b;

	modport source (output valid, output uniform_a, output uniform_b, input ready);
	modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface pgt_out_if
	import pgt_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] value_first;
	logic signed [OW-1:0] value_second;
	logic                 last;

	modport source (output valid, output value_first, output value_second, output last,
		input ready);
	modport sink   (input valid, input value_first, input value_second, input last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/polar_gaussian_transform_core.sv =====
// Marsaglia polar Gaussian transform core.
//
// sample_in carries one word per pair of uniform samples (17-bit, value/65536
// in [0,1]). Each pair maps to x = 2u-1; pairs with w = x1^2+x2^2 outside
// (0,1) are dropped and produce no result word. Accepted pairs return
// x*sqrt(-2ln(w)/w)*scale as signed Q8.16, saturated.
// result_out: in pair mode one word with both values and last=1; in serial
// mode two words, the second sample's value first (last=0), then the first
// sample's value (last=1), value_second zero.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 scale (Q4.12), index 1
// serial_mode; write only while the core is empty.
// Pipeline: 4 front stages, 33 log/divide iteration stages, 4 ln/multiply
// stages, 20 square-root stages, scale stage, output register. Throughput:
// one pair per cycle in pair mode while result_out is ready; serial mode
// holds the output register and the pipeline until both words are taken.
// Reset clears all valid bits, scale to 1.0 and pair mode. When result_out
// stalls, the whole pipeline holds; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module polar_gaussian_transform_core
	import pgt_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [0:0]     cfg_index,
	input  wire logic [SCW-1:0] cfg_wdata,
	pgt_in_if.sink              sample_in,
	pgt_out_if.source           result_out
);

	// configuration registers
	logic [SCW-1:0] scale_q;
	logic           serial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			serial_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE:  scale_q  <= cfg_wdata;
				REG_SERIAL: serial_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// one global advance: every stage moves when the output register frees up
	logic adv;
	assign sample_in.ready = adv;

	iter_t it [0:ITER_STAGES];
	sqrt_t sq [0:SQRT_STAGES];

	// clamp, square, reject, normalize
	pgt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (sample_in.valid),
		.ua     (sample_in.uniform_a),
		.ub     (sample_in.uniform_b),
		.o_q    (it[0])
	);

	// log2 squaring chain and both x^2/w dividers, one bit per stage
	for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
		pgt_iter_stage #(.IDX(g)) u_iter (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.i_d    (it[g]),
			.o_q    (it[g+1])
		);
	end

	// -2 ln(w) * x^2 / w
	pgt_lnmul u_lnmul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.i_d    (it[ITER_STAGES]),
		.o      (sq[0])
	);

	// square root, one result bit per stage
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		pgt_sqrt_stage #(.IDX(g)) u_sqrt (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.i_d    (sq[g]),
			.o_q    (sq[g+1])
		);
	end

	// scale, saturate, hold the result word, split it in serial mode
	pgt_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.i_d         (sq[SQRT_STAGES]),
		.scale       (scale_q),
		.serial_mode (serial_q),
		.adv         (adv),
		.res         (result_out)
	);

endmodule

`default_nettype wire

// ===== rtl/core/pgt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgt_front
	import pgt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [UW-1:0] ua,
	input  wire logic [UW-1:0] ub,
	output iter_t              o_q
);

	localparam logic [UW:0] ONE = (UW+1)'(1) << FRAC_BITS;

	// clamp, map to |2u-1|, return {neg, x}
	function automatic logic [XW:0] fold(input logic [UW-1:0] u);
		logic [UW:0] uc;
		logic [UW:0] a;
		logic        neg;
		logic [UW:0] x;
		uc  = ({1'b0, u} > ONE) ? ONE : {1'b0, u};
		a   = {uc[UW-1:0], 1'b0};
		neg = a < ONE;
		x   = neg ? (ONE - a) : (a - ONE);
		return {neg, x[XW-1:0]};
	endfunction

	logic [XW:0] f1, f2;
	assign f1 = fold(ua);
	assign f2 = fold(ub);

	logic          vld_s1, n1_s1, n2_s1;
	logic [XW-1:0] x1_s1, x2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			n1_s1  <= f1[XW];
			n2_s1  <= f2[XW];
			x1_s1  <= f1[XW-1:0];
			x2_s1  <= f2[XW-1:0];
		end
	end

	logic [2*XW-1:0] sq1, sq2;
	assign sq1 = x1_s1 * x1_s1;
	assign sq2 = x2_s1 * x2_s1;

	logic            vld_s2, n1_s2, n2_s2;
	logic [XSQW-1:0] xsq1_s2, xsq2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2  <= vld_s1;
			n1_s2   <= n1_s1;
			n2_s2   <= n2_s1;
			xsq1_s2 <= sq1[XSQW-1:0];
			xsq2_s2 <= sq2[XSQW-1:0];
		end
	end

	// drop pairs on or outside the unit circle, and the zero radius
	logic [XSQW:0] wsum;
	logic          w_ok;
	assign wsum = {1'b0, xsq1_s2} + {1'b0, xsq2_s2};
	assign w_ok = (wsum != '0) && (wsum[XSQW:WW] == '0);

	logic          vld_s3, n1_s3, n2_s3;
	logic [WW-1:0] w_s3, xsq1_s3, xsq2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3  <= vld_s2 & w_ok;
			n1_s3   <= n1_s2;
			n2_s3   <= n2_s2;
			w_s3    <= wsum[WW-1:0];
			xsq1_s3 <= xsq1_s2[WW-1:0];
			xsq2_s3 <= xsq2_s2[WW-1:0];
		end
	end

	// normalize w to a Q1.31 mantissa
	logic [KW-1:0] k;
	logic [MW-1:0] m;
	iter_t         nx;

	always_comb begin
		k = '0;
		for (int i = 0; i < WW; i++) begin
			if (w_s3[i]) k = KW'(i);
		end
		m = w_s3 << (KW'(MW-1) - k);
	end

	always_comb begin
		nx      = '0;
		nx.vld  = vld_s3;
		nx.neg1 = n1_s3;
		nx.neg2 = n2_s3;
		nx.k    = k;
		nx.m    = m;
		nx.d    = w_s3;
		nx.rem1 = {1'b0, xsq1_s3};
		nx.rem2 = {1'b0, xsq2_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q.vld <= 1'b0;
		end else if (en) begin
			o_q <= nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_iter_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgt_iter_stage
	import pgt_pkg::*;
#(
	parameter int IDX = 0
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  iter_t     i_d,
	output iter_t     o_q
);

	localparam bit DO_LOG = IDX < LOG_STEPS;
	localparam int YPOS   = (IDX < LOG_STEPS) ? (LOG_STEPS - 1 - IDX) : 0;
	localparam int QPOS   = QW - 1 - IDX;

	// one restoring quotient bit: {bit, remainder}
	function automatic logic [QW:0] div_step(input logic [QW-1:0] rem,
		input logic [WW-1:0] d);
		logic [QW-1:0] rs;
		logic          ge;
		rs = (IDX == 0) ? rem : {rem[QW-2:0], 1'b0};
		ge = rs >= {1'b0, d};
		return {ge, ge ? (rs - {1'b0, d}) : rs};
	endfunction

	logic [2*MW-1:0] sq;
	logic [MW:0]     t;
	logic [QW:0]     s1, s2;
	iter_t           nx;

	assign sq = i_d.m * i_d.m;
	assign t  = sq[2*MW-1:MW-1];
	assign s1 = div_step(i_d.rem1, i_d.d);
	assign s2 = div_step(i_d.rem2, i_d.d);

	always_comb begin
		nx = i_d;
		if (DO_LOG) begin
			if (t[MW]) begin
				nx.m       = t[MW:1];
				nx.y[YPOS] = 1'b1;
			end else begin
				nx.m = t[MW-1:0];
			end
		end
		nx.q1[QPOS] = s1[QW];
		nx.q2[QPOS] = s2[QW];
		nx.rem1     = s1[QW-1:0];
		nx.rem2     = s2[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q.vld <= 1'b0;
		end else if (en) begin
			o_q <= nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_lnmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgt_lnmul
	import pgt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  iter_t     i_d,
	output sqrt_t     o
);

	logic [NLW-1:0] nl_c;
	assign nl_c = ((NLW'(LOG_STEPS) - NLW'(i_d.k)) << YW) - NLW'(i_d.y);

	logic           vld_s1, n1_s1, n2_s1;
	logic [NLW-1:0] nl_s1;
	logic [R8W-1:0] ra_s1, rb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= i_d.vld;
			n1_s1  <= i_d.neg1;
			n2_s1  <= i_d.neg2;
			nl_s1  <= nl_c;
			ra_s1  <= i_d.q1[QW-1:8];
			rb_s1  <= i_d.q2[QW-1:8];
		end
	end

	// -ln(w) = -log2(w) * ln2, integer and fraction parts separately
	logic [NLW-1:0]  hp;
	logic [2*YW-1:0] lp;
	assign hp = NLW'(nl_s1[NLW-1:YW]) * NLW'(LN2_Q32);
	assign lp = nl_s1[YW-1:0] * LN2_Q32;

	logic           vld_s2, n1_s2, n2_s2;
	logic [NLW-1:0] hp_s2;
	logic [YW-1:0]  lp_s2;
	logic [R8W-1:0] ra_s2, rb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			n1_s2  <= n1_s1;
			n2_s2  <= n2_s1;
			hp_s2  <= hp;
			lp_s2  <= lp[2*YW-1:YW];
			ra_s2  <= ra_s1;
			rb_s2  <= rb_s1;
		end
	end

	logic           vld_s3, n1_s3, n2_s3;
	logic [NLW-1:0] nln_s3;
	logic [R8W-1:0] ra_s3, rb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
			n1_s3  <= n1_s2;
			n2_s3  <= n2_s2;
			nln_s3 <= hp_s2 + NLW'(lp_s2);
			ra_s3  <= ra_s2;
			rb_s3  <= rb_s2;
		end
	end

	logic [PW-1:0] pa, pb;
	assign pa = nln_s3 * ra_s3;
	assign pb = nln_s3 * rb_s3;

	logic          vld_s4, n1_s4, n2_s4;
	logic [PW-1:0] pa_s4, pb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			n1_s4  <= n1_s3;
			n2_s4  <= n2_s3;
			pa_s4  <= pa;
			pb_s4  <= pb;
		end
	end

	always_comb begin
		o      = '0;
		o.vld  = vld_s4;
		o.neg1 = n1_s4;
		o.neg2 = n2_s4;
		o.v1   = TW'(pa_s4[PW-1:23]);
		o.v2   = TW'(pb_s4[PW-1:23]);
	end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_sqrt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgt_sqrt_stage
	import pgt_pkg::*;
#(
	parameter int IDX = 0
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  sqrt_t     i_d,
	output sqrt_t     o_q
);

	localparam logic [TW-1:0] BIT = TW'(1) << (TW - 2 - 2 * IDX);

	// one digit of the bitwise integer square root: {v, res}
	function automatic logic [2*TW-1:0] sq_step(input logic [TW-1:0] v,
		input logic [TW-1:0] res);
		logic [TW-1:0] trial;
		trial = res + BIT;
		if (v >= trial) begin
			return {v - trial, (res >> 1) + BIT};
		end
		return {v, res >> 1};
	endfunction

	logic [2*TW-1:0] s1, s2;
	sqrt_t           nx;

	assign s1 = sq_step(i_d.v1, i_d.res1);
	assign s2 = sq_step(i_d.v2, i_d.res2);

	always_comb begin
		nx      = i_d;
		nx.v1   = s1[2*TW-1:TW];
		nx.res1 = s1[TW-1:0];
		nx.v2   = s2[2*TW-1:TW];
		nx.res2 = s2[TW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q.vld <= 1'b0;
		end else if (en) begin
			o_q <= nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgt_out
	import pgt_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sqrt_t               i_d,
	input  wire logic [SCW-1:0] scale,
	input  wire logic           serial_mode,
	output logic                adv,
	pgt_out_if.source           res
);

	// saturate a magnitude with sign to signed Q8.16
	function automatic logic [OW-1:0] to_q816(input logic [OW-1:0] mag, input logic neg);
		if (neg) begin
			return mag[OW-1] ? OUT_MIN : (~mag + OW'(1));
		end
		return mag[OW-1] ? OUT_MAX : mag;
	endfunction

	logic                 vld_o1, n1_o1, n2_o1;
	logic [SW+SCW-1:0]    m1_o1, m2_o1;
	logic                 out_vld_q, phase_q;
	logic [OW-1:0]        v1_q, v2_q;
	logic                 beat_done;

	assign beat_done = res.ready & (~serial_mode | phase_q);
	assign adv       = ~out_vld_q | beat_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o1 <= 1'b0;
		end else if (adv) begin
			vld_o1 <= i_d.vld;
			n1_o1  <= i_d.neg1;
			n2_o1  <= i_d.neg2;
			m1_o1  <= i_d.res1[SW-1:0] * scale;
			m2_o1  <= i_d.res2[SW-1:0] * scale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_o1;
			phase_q   <= 1'b0;
			v1_q      <= to_q816(m1_o1[SW+SCW-1:12], n1_o1);
			v2_q      <= to_q816(m2_o1[SW+SCW-1:12], n2_o1);
		end else if (res.ready && serial_mode) begin
			phase_q <= 1'b1;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.value_first  = (serial_mode && !phase_q) ? v2_q : v1_q;
	assign res.value_second = serial_mode ? '0 : v2_q;
	assign res.last         = ~serial_mode | phase_q;

endmodule

`default_nettype wire
